FILE: rtl/otb_pkg.sv
// Package of shared types and constants for the Otsu threshold binarizer.
`default_nettype none
package otb_pkg;

  localparam int COUNT_BITS_DEF = 20;
  localparam int BINS_DEF       = 256;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic       CMD_HIST  = 1'b0;
  localparam logic       CMD_BIN   = 1'b1;
  localparam logic       KIND_THR  = 1'b0;
  localparam logic       KIND_PIX  = 1'b1;
  localparam logic [7:0] PIX_HIGH  = 8'd255;
  localparam logic [7:0] PIX_LOW   = 8'd0;

  typedef struct packed {
    logic       command;
    logic [7:0] pixel;
    logic       last;
  } item_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_HWR, ST_P1RD, ST_P1AC, ST_P2RD, ST_P2UP, ST_CHK,
    ST_MSTART, ST_MWAIT, ST_ABS, ST_CMP, ST_NEXT, ST_CLRL, ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    OP_C0S, OP_NS0, OP_AA, OP_DEN, OP_L, OP_R
  } op_t;

endpackage
`default_nettype wire

FILE: rtl/otb_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module otb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end
endmodule
`default_nettype wire

FILE: rtl/otb_fifo.sv
// Short input queue between the accepting front and the executing back.
`default_nettype none
module otb_fifo
  import otb_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        push,
  input  wire item_t push_item,
  output logic       full,
  output logic       q_valid,
  output item_t      q_item,
  input  wire        q_pop
);
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  item_t         mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(QUEUE_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_item  = mem_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wp_r] <= push_item;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/otb_mul.sv
// Shift-and-add multiplier that handles one bit of the second operand per cycle.
`default_nettype none
module otb_mul #(
  parameter int W = 16
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              start,
  input  wire  [W-1:0]     x,
  input  wire  [W-1:0]     y,
  output logic             done,
  output logic [2*W-1:0]   prod
);
  logic           busy_r, busy_nxt;
  logic [2*W-1:0] xs_r, xs_nxt, acc_r, acc_nxt;
  logic [W-1:0]   ys_r, ys_nxt;

  assign done = busy_r && (ys_r == '0);
  assign prod = acc_r;

  always_comb begin
    busy_nxt = busy_r;
    xs_nxt   = xs_r;
    ys_nxt   = ys_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      xs_nxt   = (2*W)'(x);
      ys_nxt   = y;
      acc_nxt  = '0;
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (busy_r) begin
      if (ys_r[0]) begin
        acc_nxt = acc_r + xs_r;
      end
      xs_nxt = xs_r << 1;
      ys_nxt = ys_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    xs_r  <= xs_nxt;
    ys_r  <= ys_nxt;
    acc_r <= acc_nxt;
  end
endmodule
`default_nettype wire

FILE: rtl/otb_core.sv
// Back end: histogram update, threshold search, binarizing and the result register.
`default_nettype none
module otb_core
  import otb_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int BINS       = BINS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         q_valid,
  input  wire item_t  q_item,
  output logic        q_pop,
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic        out_tuser,
  output logic [15:0] out_tdata
);
  localparam int BB = $clog2(BINS);
  localparam int NW = COUNT_BITS + BB;
  localparam int SW = NW + BB;
  localparam int AW = NW + SW;
  localparam int MW = 2 * AW;
  localparam int DW = 2 * NW;
  localparam int LW = MW + DW;

  state_t                state_r, state_nxt;
  op_t                   op_r, op_nxt;
  logic [BB-1:0]         idx_r, idx_nxt, hbin_r, hbin_nxt, best_r, best_nxt, pix_bin;
  logic                  hlast_r, hlast_nxt, have_r, have_nxt;
  logic [NW-1:0]         n_r, n_nxt, c0_r, c0_nxt, c1;
  logic [SW-1:0]         s_r, s_nxt, s0_r, s0_nxt;
  logic [AW-1:0]         p1_r, p1_nxt, p2_r, p2_nxt, a_r, a_nxt, diff;
  logic [MW-1:0]         num_r, num_nxt, bnum_r, bnum_nxt;
  logic [DW-1:0]         den_r, den_nxt, bden_r, bden_nxt;
  logic [LW-1:0]         lhs_r, lhs_nxt, rhs_r, rhs_nxt;
  logic [7:0]            thr_r, thr_nxt;
  logic                  ov_r, ov_nxt, ok_r, ok_nxt;
  logic [7:0]            ot_r, ot_nxt, op_pix_r, op_pix_nxt;
  logic                  out_free, last_idx, last_t;

  logic                  ram_we;
  logic [BB-1:0]         ram_waddr, ram_raddr;
  logic [COUNT_BITS-1:0] ram_wdata, ram_rdata;
  logic                  mul_start, mul_done;
  logic [MW-1:0]         mul_x, mul_y;
  logic [2*MW-1:0]       mul_prod;

  otb_ram #(.WIDTH(COUNT_BITS), .DEPTH(BINS)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  otb_mul #(.W(MW)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .x(mul_x), .y(mul_y),
    .done(mul_done), .prod(mul_prod)
  );

  assign out_free   = !ov_r || out_tready;
  assign last_idx   = (idx_r == BB'(BINS - 1));
  assign last_t     = (idx_r == BB'(BINS - 2));
  assign c1         = n_r - c0_r;
  assign diff       = (p1_r > p2_r) ? (p1_r - p2_r) : (p2_r - p1_r);
  assign pix_bin    = (32'(q_item.pixel) >= BINS) ? BB'(BINS - 1) : BB'(q_item.pixel);
  assign out_tvalid = ov_r;
  assign out_tuser  = ok_r;
  assign out_tdata  = {op_pix_r, ot_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:  if (last_idx) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (q_valid && q_item.command == CMD_HIST) begin
          state_nxt = ST_HWR;
        end
      end
      ST_HWR:    state_nxt = hlast_r ? ST_P1RD : ST_IDLE;
      ST_P1RD:   state_nxt = ST_P1AC;
      ST_P1AC:   state_nxt = last_idx ? ST_P2RD : ST_P1RD;
      ST_P2RD:   state_nxt = ST_P2UP;
      ST_P2UP:   state_nxt = ST_CHK;
      ST_CHK:    state_nxt = (c0_r == '0 || c1 == '0) ? ST_NEXT : ST_MSTART;
      ST_MSTART: state_nxt = ST_MWAIT;
      ST_MWAIT: begin
        if (mul_done) begin
          case (op_r)
            OP_NS0:  state_nxt = ST_ABS;
            OP_DEN:  state_nxt = have_r ? ST_MSTART : ST_NEXT;
            OP_R:    state_nxt = ST_CMP;
            default: state_nxt = ST_MSTART;
          endcase
        end
      end
      ST_ABS:    state_nxt = (diff == '0) ? ST_NEXT : ST_MSTART;
      ST_CMP:    state_nxt = ST_NEXT;
      ST_NEXT:   state_nxt = last_t ? ST_CLRL : ST_P2RD;
      ST_CLRL:   state_nxt = ST_OUT;
      ST_OUT:    if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    op_nxt     = op_r;
    idx_nxt    = idx_r;
    hbin_nxt   = hbin_r;
    hlast_nxt  = hlast_r;
    best_nxt   = best_r;
    have_nxt   = have_r;
    n_nxt      = n_r;
    s_nxt      = s_r;
    c0_nxt     = c0_r;
    s0_nxt     = s0_r;
    p1_nxt     = p1_r;
    p2_nxt     = p2_r;
    a_nxt      = a_r;
    num_nxt    = num_r;
    den_nxt    = den_r;
    bnum_nxt   = bnum_r;
    bden_nxt   = bden_r;
    lhs_nxt    = lhs_r;
    rhs_nxt    = rhs_r;
    thr_nxt    = thr_r;
    ov_nxt     = ov_r && !out_tready;
    ok_nxt     = ok_r;
    ot_nxt     = ot_r;
    op_pix_nxt = op_pix_r;
    q_pop      = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = idx_r;
    ram_wdata  = '0;
    ram_raddr  = idx_r;
    mul_start  = 1'b0;
    mul_x      = '0;
    mul_y      = '0;
    case (state_r)
      ST_CLEAR: begin
        ram_we  = 1'b1;
        idx_nxt = last_idx ? '0 : idx_r + 1'b1;
      end
      ST_IDLE: begin
        if (q_valid) begin
          if (q_item.command == CMD_HIST) begin
            q_pop     = 1'b1;
            ram_raddr = pix_bin;
            hbin_nxt  = pix_bin;
            hlast_nxt = q_item.last;
          end else if (out_free) begin
            q_pop      = 1'b1;
            ov_nxt     = 1'b1;
            ok_nxt     = KIND_PIX;
            ot_nxt     = thr_r;
            op_pix_nxt = (q_item.pixel > thr_r) ? PIX_HIGH : PIX_LOW;
          end
        end
      end
      ST_HWR: begin
        ram_we    = 1'b1;
        ram_waddr = hbin_r;
        ram_wdata = (ram_rdata == '1) ? ram_rdata : ram_rdata + 1'b1;
        idx_nxt   = '0;
        n_nxt     = '0;
        s_nxt     = '0;
      end
      ST_P1AC: begin
        n_nxt = n_r + NW'(ram_rdata);
        s_nxt = s_r + SW'(SW'(ram_rdata) * SW'(idx_r));
        if (last_idx) begin
          idx_nxt  = '0;
          c0_nxt   = '0;
          s0_nxt   = '0;
          have_nxt = 1'b0;
          best_nxt = '0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_P2UP: begin
        c0_nxt = c0_r + NW'(ram_rdata);
        s0_nxt = s0_r + SW'(SW'(ram_rdata) * SW'(idx_r));
        ram_we = 1'b1;
      end
      ST_CHK:  op_nxt = OP_C0S;
      ST_MSTART: begin
        mul_start = 1'b1;
        case (op_r)
          OP_C0S:  begin mul_x = MW'(s_r);    mul_y = MW'(c0_r); end
          OP_NS0:  begin mul_x = MW'(s0_r);   mul_y = MW'(n_r);  end
          OP_AA:   begin mul_x = MW'(a_r);    mul_y = MW'(a_r);  end
          OP_DEN:  begin mul_x = MW'(c0_r);   mul_y = MW'(c1);   end
          OP_L:    begin mul_x = num_r;       mul_y = MW'(bden_r); end
          OP_R:    begin mul_x = bnum_r;      mul_y = MW'(den_r); end
          default: begin mul_x = '0;          mul_y = '0;        end
        endcase
      end
      ST_MWAIT: begin
        if (mul_done) begin
          case (op_r)
            OP_C0S: begin p1_nxt = mul_prod[AW-1:0]; op_nxt = OP_NS0; end
            OP_NS0:  p2_nxt = mul_prod[AW-1:0];
            OP_AA:  begin num_nxt = mul_prod[MW-1:0]; op_nxt = OP_DEN; end
            OP_DEN: begin
              den_nxt = mul_prod[DW-1:0];
              if (!have_r) begin
                have_nxt = 1'b1;
                best_nxt = idx_r;
                bnum_nxt = num_r;
                bden_nxt = mul_prod[DW-1:0];
              end else begin
                op_nxt = OP_L;
              end
            end
            OP_L:   begin lhs_nxt = mul_prod[LW-1:0]; op_nxt = OP_R; end
            OP_R:    rhs_nxt = mul_prod[LW-1:0];
            default: op_nxt = op_r;
          endcase
        end
      end
      ST_ABS: begin
        a_nxt  = diff;
        op_nxt = OP_AA;
      end
      ST_CMP: begin
        if (lhs_r > rhs_r) begin
          best_nxt = idx_r;
          bnum_nxt = num_r;
          bden_nxt = den_r;
        end
      end
      ST_NEXT: if (!last_t) idx_nxt = idx_r + 1'b1;
      ST_CLRL: begin
        ram_we    = 1'b1;
        ram_waddr = BB'(BINS - 1);
      end
      ST_OUT: begin
        if (out_free) begin
          ov_nxt     = 1'b1;
          ok_nxt     = KIND_THR;
          ot_nxt     = 8'(best_r);
          op_pix_nxt = PIX_LOW;
          thr_nxt    = 8'(best_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      idx_r   <= '0;
      ov_r    <= 1'b0;
      thr_r   <= '0;
      have_r  <= 1'b0;
      op_r    <= OP_C0S;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      ov_r    <= ov_nxt;
      thr_r   <= thr_nxt;
      have_r  <= have_nxt;
      op_r    <= op_nxt;
    end
    hbin_r   <= hbin_nxt;
    hlast_r  <= hlast_nxt;
    best_r   <= best_nxt;
    n_r      <= n_nxt;
    s_r      <= s_nxt;
    c0_r     <= c0_nxt;
    s0_r     <= s0_nxt;
    p1_r     <= p1_nxt;
    p2_r     <= p2_nxt;
    a_r      <= a_nxt;
    num_r    <= num_nxt;
    den_r    <= den_nxt;
    bnum_r   <= bnum_nxt;
    bden_r   <= bden_nxt;
    lhs_r    <= lhs_nxt;
    rhs_r    <= rhs_nxt;
    ok_r     <= ok_nxt;
    ot_r     <= ot_nxt;
    op_pix_r <= op_pix_nxt;
  end
endmodule
`default_nettype wire

FILE: rtl/otsu_threshold_binarizer_unit.sv
// Top level of the Otsu threshold binarizer: input queue and execution back end.
//
//   channel  direction  tdata                                 tuser     tlast
//   in_      slave      [7:0] pixel                           command   last
//   out_     master     [7:0] threshold, [15:8] binary_pixel  kind      none
//
// A binarize transaction is taken when the output register is free; a histogram
// transaction reads the RAM bin, then writes the count back. After the last pixel
// the search reads and accumulates every bin for the totals, then per candidate
// threshold runs up to six serial multiplications of one operand bit per cycle.
// After reset a pass clears every bin before any input transaction is taken. The
// output register lets a new input transaction be queued while a result waits.
`default_nettype none
module otsu_threshold_binarizer_unit
  import otb_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int BINS       = BINS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // pixel
  input  wire         in_tuser,   // command
  input  wire         in_tlast,   // last
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [15:0] out_tdata,  // threshold, binary_pixel
  output logic        out_tuser   // kind
);
  item_t in_item, q_item;
  logic  full, q_valid, q_pop;

  assign in_item.command = in_tuser;
  assign in_item.pixel   = in_tdata;
  assign in_item.last    = in_tlast;
  assign in_tready       = !full;

  otb_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(in_tvalid), .push_item(in_item), .full(full),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  otb_core #(.COUNT_BITS(COUNT_BITS), .BINS(BINS)) u_core (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tuser(out_tuser),
    .out_tdata(out_tdata)
  );
endmodule
`default_nettype wire

FILE: test/otsu_threshold_binarizer_unit_tb.sv
// Self-checking testbench for the Otsu threshold binarizer: histogram frames and binarize traffic.
module otsu_threshold_binarizer_unit_tb
  import otb_pkg::*;
();

  localparam int CNT_W = COUNT_BITS_DEF;
  localparam int NBINS = BINS_DEF;

  typedef struct {
    logic       kind;
    logic [7:0] threshold;
    logic [7:0] binary_pixel;
  } otsu_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;    // pixel
  logic        in_tuser = 1'b0;  // command
  logic        in_tlast = 1'b0;  // last
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;        // threshold, binary_pixel
  logic        out_tuser;        // kind

  logic [CNT_W-1:0] hist_model [NBINS];
  logic [7:0]       model_threshold;
  otsu_result_t     pending_results [$];
  int               tx_idle_pct;
  int               rx_stall_pct;
  int               mismatch_count;
  int               result_count;
  int               frame_count;
  int               binarize_count;

  otsu_threshold_binarizer_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [7:0] otsu_pick_threshold();
    logic [319:0] n, s, c0, s0, c1, lhs, rhs, diff, num, den, best_num, best_den;
    logic         have;
    int           best;
    n = '0; s = '0; c0 = '0; s0 = '0;
    best_num = '0; best_den = '0; have = 1'b0; best = 0;
    for (int j = 0; j < NBINS; j++) begin
      n += 320'(hist_model[j]);
      s += 320'(hist_model[j]) * 320'(j);
    end
    for (int t = 0; t < NBINS - 1; t++) begin
      c0 += 320'(hist_model[t]);
      s0 += 320'(hist_model[t]) * 320'(t);
      c1 = n - c0;
      if (c0 != 0 && c1 != 0) begin
        lhs = c0 * s;
        rhs = n * s0;
        diff = (lhs > rhs) ? lhs - rhs : rhs - lhs;
        if (diff != 0) begin
          num = diff * diff;
          den = c0 * c1;
          if (!have || num * best_den > best_num * den) begin
            have = 1'b1;
            best = t;
            best_num = num;
            best_den = den;
          end
        end
      end
    end
    return best[7:0];
  endfunction

  task automatic predict_item(input logic cmd, input logic [7:0] pix, input logic lst);
    otsu_result_t r;
    if (cmd == CMD_BIN) begin
      r.kind = KIND_PIX;
      r.threshold = model_threshold;
      r.binary_pixel = (pix > model_threshold) ? PIX_HIGH : PIX_LOW;
      pending_results.insert(pending_results.size(), r);
      binarize_count++;
    end else begin
      if (hist_model[pix] != '1) hist_model[pix] = hist_model[pix] + 1'b1;
      if (lst) begin
        model_threshold = otsu_pick_threshold();
        for (int j = 0; j < NBINS; j++) hist_model[j] = '0;
        r.kind = KIND_THR;
        r.threshold = model_threshold;
        r.binary_pixel = PIX_LOW;
        pending_results.insert(pending_results.size(), r);
        frame_count++;
      end
    end
  endtask

  task automatic send_item(input logic cmd, input logic [7:0] pix, input logic lst);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= pix;
    in_tlast <= lst;
    do @(posedge clk); while (!in_tready);
    predict_item(cmd, pix, lst);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    otsu_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      result_count++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transaction, kind", out_tuser, -1);
      end else begin
        e = pending_results.pop_front();
        if (out_tuser !== e.kind) report_mismatch("kind", out_tuser, e.kind);
        if (out_tdata[7:0] !== e.threshold)
          report_mismatch("threshold", out_tdata[7:0], e.threshold);
        if (out_tdata[15:8] !== e.binary_pixel)
          report_mismatch("binary_pixel", out_tdata[15:8], e.binary_pixel);
      end
    end
  end

  task automatic test_binarize_extremes();
    send_item(CMD_BIN, 8'd0, 1'b0);
    send_item(CMD_BIN, 8'd255, 1'b1);
    send_item(CMD_BIN, 8'd1, 1'b0);
  endtask

  task automatic test_directed_frames();
    // A frame of one grey level has no split with two populated classes.
    repeat (4) send_item(CMD_HIST, 8'd100, 1'b0);
    send_item(CMD_HIST, 8'd100, 1'b1);
    send_item(CMD_HIST, 8'd255, 1'b1);
    // Two clusters give a clear split at the lower one.
    repeat (3) send_item(CMD_HIST, 8'd50, 1'b0);
    repeat (2) send_item(CMD_HIST, 8'd200, 1'b0);
    send_item(CMD_HIST, 8'd200, 1'b1);
    send_item(CMD_BIN, 8'd50, 1'b0);
    send_item(CMD_BIN, 8'd51, 1'b1);
    send_item(CMD_BIN, 8'd255, 1'b0);
    // Extremes only: every threshold ties, so the smallest one is kept.
    send_item(CMD_HIST, 8'd0, 1'b0);
    send_item(CMD_HIST, 8'd255, 1'b1);
    send_item(CMD_BIN, 8'd0, 1'b0);
    send_item(CMD_BIN, 8'd128, 1'b0);
  endtask

  task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int n_items);
    int       frame_len, frame_pos, lo_c, hi_c, spread;
    logic [7:0] pix;
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    frame_pos = 0;
    frame_len = $urandom_range(120, 40);
    lo_c = $urandom_range(127);
    hi_c = $urandom_range(255, 128);
    spread = $urandom_range(20, 1);
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(99) < 15) begin
        send_item(CMD_BIN, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end else begin
        if ($urandom_range(9) == 0) pix = 8'($urandom_range(255));
        else if ($urandom_range(1)) pix = 8'(lo_c + $urandom_range(spread));
        else pix = 8'(hi_c - $urandom_range(spread));
        frame_pos++;
        if (frame_pos >= frame_len || i == n_items - 1) begin
          send_item(CMD_HIST, pix, 1'b1);
          frame_pos = 0;
          frame_len = $urandom_range(120, 40);
          lo_c = $urandom_range(127);
          hi_c = $urandom_range(255, 128);
          spread = $urandom_range(20, 1);
        end else begin
          send_item(CMD_HIST, pix, 1'b0);
        end
      end
    end
  endtask

  initial begin
    for (int j = 0; j < NBINS; j++) hist_model[j] = '0;
    model_threshold = 8'd0;
    mismatch_count = 0;
    result_count = 0;
    frame_count = 0;
    binarize_count = 0;
    tx_idle_pct = 11;
    rx_stall_pct = 65;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_binarize_extremes();
    test_directed_frames();
    test_random_traffic(11, 65, 245);
    test_random_traffic(65, 11, 245);
    test_random_traffic(0, 0, 245);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Covered %0d frames and %0d binarize transactions, %0d results checked.",
             frame_count, binarize_count, result_count);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("Timeout with %0d results outstanding.", pending_results.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
